>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent assertions used by met_seq
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion sampled on the rising clock edge, off while reset is high
`define MET_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// assertion sampled on the rising clock edge, also checked during reset
`define MET_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/met_pkg.sv
// ----------------------------------------------------------------------------
// met_pkg
// shared widths, register codes, reset values, types and saturation function of the escape-time unit
// ----------------------------------------------------------------------------
package met_pkg;

   localparam int PIX_W         = 12;
   localparam int CNT_W         = 16;
   localparam int VAL_W         = 32;
   localparam int STEP_W        = 31;
   localparam int PROD_W        = 64;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int MAX_DIM_DEF   = 4096;
   localparam int FRAC_BITS_DEF = 28;

   localparam logic signed [VAL_W-1:0] ORIGIN_RE_RST = -32'sd563714458;
   localparam logic signed [VAL_W-1:0] ORIGIN_IM_RST = -32'sd322122547;
   localparam logic [STEP_W-1:0]       STEP_RE_RST   = 31'd707789;
   localparam logic [STEP_W-1:0]       STEP_IM_RST   = 31'd629146;
   localparam logic [CNT_W-1:0]        LIMIT_RST     = 16'd256;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_RE = 3'd0,
      CSR_ORIGIN_IM = 3'd1,
      CSR_STEP_RE   = 3'd2,
      CSR_STEP_IM   = 3'd3,
      CSR_LIMIT     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] origin_re;
      logic signed [VAL_W-1:0] origin_im;
      logic [STEP_W-1:0]       step_re;
      logic [STEP_W-1:0]       step_im;
      logic [CNT_W-1:0]        limit;
   } cfg_type;

   typedef struct packed {
      logic                    load;
      logic signed [VAL_W-1:0] a0;
      logic signed [VAL_W-1:0] b0;
      logic signed [VAL_W-1:0] a1;
      logic signed [VAL_W-1:0] b1;
      logic signed [VAL_W-1:0] a2;
      logic signed [VAL_W-1:0] b2;
   } mul_req_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] p0;
      logic signed [PROD_W-1:0] p1;
      logic signed [PROD_W-1:0] p2;
   } mul_rsp_type;

   function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [PROD_W-1:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return v[VAL_W-1:0];
      end
   endfunction

endpackage

>>> sv/met_req_if.sv
// ----------------------------------------------------------------------------
// met_req_if
// pixel request channel: valid, ready, column and row
// ----------------------------------------------------------------------------
interface met_req_if
   import met_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_col;
   logic [PIX_W-1:0] pixel_row;

   modport source (output valid, output pixel_col, output pixel_row, input ready);
   modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

>>> sv/met_rsp_if.sv
// ----------------------------------------------------------------------------
// met_rsp_if
// result channel: valid, ready, iteration count and limit flag
// ----------------------------------------------------------------------------
interface met_rsp_if
   import met_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] iteration_count;
   logic             reached_limit;

   modport source (output valid, output iteration_count, output reached_limit, input ready);
   modport sink   (input valid, input iteration_count, input reached_limit, output ready);
endinterface

>>> sv/met_csr.sv
// ----------------------------------------------------------------------------
// met_csr
// configuration registers: window origin, pixel steps and iteration limit
// ----------------------------------------------------------------------------
module met_csr
   import met_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ORIGIN_RE: cfg_in.origin_re = signed'(csr_wdata[VAL_W-1:0]);
            CSR_ORIGIN_IM: cfg_in.origin_im = signed'(csr_wdata[VAL_W-1:0]);
            CSR_STEP_RE:   cfg_in.step_re   = csr_wdata[STEP_W-1:0];
            CSR_STEP_IM:   cfg_in.step_im   = csr_wdata[STEP_W-1:0];
            CSR_LIMIT:     cfg_in.limit     = csr_wdata[CNT_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_re <= ORIGIN_RE_RST;
         cfg_ff.origin_im <= ORIGIN_IM_RST;
         cfg_ff.step_re   <= STEP_RE_RST;
         cfg_ff.step_im   <= STEP_IM_RST;
         cfg_ff.limit     <= LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/met_mul.sv
// ----------------------------------------------------------------------------
// met_mul
// shared multiplier unit: three registered 32x32 signed products
// ----------------------------------------------------------------------------
module met_mul
   import met_pkg::*;
(
   input  logic        clock,
   input  mul_req_type mreq,
   output mul_rsp_type mrsp
);

   mul_rsp_type prod_ff;
   mul_rsp_type prod_in;

   always_comb begin
      prod_in.p0 = PROD_W'(mreq.a0) * PROD_W'(mreq.b0);
      prod_in.p1 = PROD_W'(mreq.a1) * PROD_W'(mreq.b1);
      prod_in.p2 = PROD_W'(mreq.a2) * PROD_W'(mreq.b2);
   end

   always_ff @(posedge clock) begin
      if (mreq.load) begin
         prod_ff <= prod_in;
      end
   end

   assign mrsp = prod_ff;

endmodule

>>> sv/met_seq.sv
// ----------------------------------------------------------------------------
// met_seq
// sequencer: pixel mapping, iteration loop, escape test and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module met_seq
   import met_pkg::*;
#(
   parameter int MAX_DIM   = MAX_DIM_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   met_req_if.sink     req,
   met_rsp_if.source   rsp,
   output mul_req_type mreq,
   input  mul_rsp_type mrsp
);

   localparam logic [PIX_W-1:0] PIX_MAX =
      ((MAX_DIM - 1) >= ((1 << PIX_W) - 1)) ? {PIX_W{1'b1}} : PIX_W'(MAX_DIM - 1);
   localparam bit ESC_ON = (2 * FRAC_BITS + 2) < PROD_W;
   localparam logic [PROD_W-1:0] ESC_LIM =
      ESC_ON ? (PROD_W'(1) << (2 * FRAC_BITS + 2)) : '0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_INIT,
      ST_SQR,
      ST_STEP
   } state_type;

   state_type               state_ff, state_in;
   logic [PIX_W-1:0]        col_ff, col_in;
   logic [PIX_W-1:0]        row_ff, row_in;
   logic signed [VAL_W-1:0] cr_ff, cr_in;
   logic signed [VAL_W-1:0] ci_ff, ci_in;
   logic signed [VAL_W-1:0] zr_ff, zr_in;
   logic signed [VAL_W-1:0] zi_ff, zi_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic                    rsp_limit_ff, rsp_limit_in;

   logic [CNT_W-1:0]         bound;
   logic [PROD_W-1:0]        mag;
   logic                     still_in;
   logic signed [PROD_W-1:0] diff;
   logic signed [PROD_W-1:0] nr;
   logic signed [PROD_W-1:0] ni;
   logic                     out_free;

   assign bound    = (cfg.limit == '0) ? '0 : cfg.limit - CNT_W'(1);
   assign mag      = PROD_W'($unsigned(mrsp.p0)) + PROD_W'($unsigned(mrsp.p1));
   assign still_in = !ESC_ON || (mag < ESC_LIM);
   assign diff     = mrsp.p0 - mrsp.p1;
   assign nr       = (diff >>> FRAC_BITS) + PROD_W'(cr_ff);
   assign ni       = (mrsp.p2 >>> (FRAC_BITS - 1)) + PROD_W'(ci_ff);
   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      mreq.load = (state_ff == ST_MAP) || (state_ff == ST_SQR);
      if (state_ff == ST_MAP) begin
         mreq.a0 = signed'(VAL_W'(col_ff));
         mreq.b0 = signed'({1'b0, cfg.step_re});
         mreq.a1 = signed'(VAL_W'(row_ff));
         mreq.b1 = signed'({1'b0, cfg.step_im});
      end else begin
         mreq.a0 = zr_ff;
         mreq.b0 = zr_ff;
         mreq.a1 = zi_ff;
         mreq.b1 = zi_ff;
      end
      mreq.a2 = zr_ff;
      mreq.b2 = zi_ff;
   end

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_count_in = rsp_count_ff;
      rsp_limit_in = rsp_limit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               col_in   = (req.pixel_col > PIX_MAX) ? PIX_MAX : req.pixel_col;
               row_in   = (req.pixel_row > PIX_MAX) ? PIX_MAX : req.pixel_row;
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            state_in = ST_INIT;
         end
         ST_INIT: begin
            cr_in    = sat_val(PROD_W'(cfg.origin_re) + mrsp.p0);
            ci_in    = sat_val(PROD_W'(cfg.origin_im) + mrsp.p1);
            zr_in    = cr_in;
            zi_in    = ci_in;
            count_in = '0;
            state_in = ST_SQR;
         end
         ST_SQR: begin
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (!still_in || (count_ff >= bound)) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = count_ff;
                  rsp_limit_in = still_in;
                  state_in     = ST_IDLE;
               end
            end else begin
               zr_in    = sat_val(nr);
               zi_in    = sat_val(ni);
               count_in = count_ff + CNT_W'(1);
               state_in = ST_SQR;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      col_ff       <= col_in;
      row_ff       <= row_in;
      cr_ff        <= cr_in;
      ci_ff        <= ci_in;
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      count_ff     <= count_in;
      rsp_count_ff <= rsp_count_in;
      rsp_limit_ff <= rsp_limit_in;
   end

   assign req.ready           = (state_ff == ST_IDLE);
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.iteration_count = rsp_count_ff;
   assign rsp.reached_limit   = rsp_limit_ff;

   `MET_ASSERT(a_count_le_bound, clock, reset, (state_ff == ST_STEP) |-> (count_ff <= bound), "iteration count passed the bound")
   `MET_ASSERT(a_accept_maps, clock, reset, (req.valid && req.ready) |=> (state_ff == ST_MAP), "accepted beat did not start pixel mapping")
   `MET_ASSERT(a_rsp_from_step, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_STEP), "result beat raised outside the escape test")
   `MET_ASSERT(a_limit_count, clock, reset, (rsp_valid_ff && rsp_limit_ff) |-> (rsp_count_ff == bound), "limit flag set with a short count")

endmodule

>>> sv/mandelbrot_escape_time_unit.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_unit
// escape-time iteration count of one pixel of a mandelbrot window
// ----------------------------------------------------------------------------
// A pixel beat is taken only while the unit is idle. It maps the pixel to
// c = origin + pixel * step in the MAP and INIT states, then runs
// z = z*z + c: each iteration forms zr*zr, zi*zi and zr*zi in the shared
// multiplier unit (SQR), then adds, saturates and tests |z|^2 < 4 (STEP).
// The next request is taken while the previous result still waits in the
// output register.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_unit
   import met_pkg::*;
#(
   parameter int MAX_DIM   = MAX_DIM_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   met_req_if.sink               req_bus,
   met_rsp_if.source             rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type     cfg;
   mul_req_type mreq;
   mul_rsp_type mrsp;

   met_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   met_mul u_mul (
      .clock (clock),
      .mreq  (mreq),
      .mrsp  (mrsp)
   );

   met_seq #(
      .MAX_DIM   (MAX_DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .mreq  (mreq),
      .mrsp  (mrsp)
   );

endmodule
